### sv/bfr_pkg.sv
// Package for the MSB-first bit field reader.
// Holds store sizing, function and error codes, and the item and result types.
// No dependencies.
package bfr_pkg;

  localparam int STORE_BITS = 64;
  localparam int HELD_W     = $clog2(STORE_BITS + 1);
  localparam int VAL_W      = 32;
  localparam int FW_W       = 6;

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_ALIGN = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNDERRUN = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]      func;
    logic [7:0]      byte_in;
    logic [FW_W-1:0] field_width;
    logic            sign_extend;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] field_value;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic [HELD_W-1:0] held;
    logic [1:0]        err;
  } stat_t;

endpackage

### sv/bfr_unit.sv
// Bit store, fill count and sticky error of the bit field reader.
// Applies one registered item per fire; depends on bfr_pkg.
module bfr_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bfr_pkg::item_t   item,
  output bfr_pkg::result_t res,
  output bfr_pkg::stat_t   stat
);

  logic [bfr_pkg::STORE_BITS-1:0] store_r, store_nxt;
  logic [bfr_pkg::HELD_W-1:0]     held_r, held_nxt;
  logic [1:0]                     err_r, err_nxt;

  logic [bfr_pkg::FW_W-1:0]       w;
  logic [bfr_pkg::FW_W-1:0]       rshift;
  logic [bfr_pkg::VAL_W-1:0]      top_bits;
  logic [bfr_pkg::VAL_W-1:0]      value;
  logic [bfr_pkg::STORE_BITS-1:0] push_bits;
  logic [bfr_pkg::HELD_W:0]       push_need;
  logic [2:0]                     odd_bits;

  always_comb begin
    w         = (item.field_width > bfr_pkg::FW_W'(bfr_pkg::VAL_W)) ?
                bfr_pkg::FW_W'(bfr_pkg::VAL_W) : item.field_width;
    rshift    = bfr_pkg::FW_W'(bfr_pkg::VAL_W) - w;
    top_bits  = store_r[bfr_pkg::STORE_BITS-1 -: bfr_pkg::VAL_W];
    push_bits = {item.byte_in, {(bfr_pkg::STORE_BITS-8){1'b0}}} >> held_r;
    push_need = {1'b0, held_r} + (bfr_pkg::HELD_W+1)'(8);
    odd_bits  = held_r[2:0];
    value     = '0;
    store_nxt = store_r;
    held_nxt  = held_r;
    err_nxt   = err_r;
    if (fire) begin
      case (item.func)
        bfr_pkg::FUNC_PUSH: begin
          if (push_need > (bfr_pkg::HELD_W+1)'(bfr_pkg::STORE_BITS)) begin
            if (err_r == bfr_pkg::ERR_NONE) err_nxt = bfr_pkg::ERR_OVERFLOW;
          end else begin
            store_nxt = store_r | push_bits;
            held_nxt  = push_need[bfr_pkg::HELD_W-1:0];
          end
        end
        bfr_pkg::FUNC_READ: begin
          if (bfr_pkg::HELD_W'(w) > held_r) begin
            if (err_r == bfr_pkg::ERR_NONE) err_nxt = bfr_pkg::ERR_UNDERRUN;
          end else if (w != '0) begin
            value = top_bits >> rshift;
            if (item.sign_extend && top_bits[bfr_pkg::VAL_W-1]) begin
              value = value | ~({bfr_pkg::VAL_W{1'b1}} >> rshift);
            end
            store_nxt = store_r << w;
            held_nxt  = held_r - bfr_pkg::HELD_W'(w);
          end
        end
        bfr_pkg::FUNC_ALIGN: begin
          store_nxt = store_r << odd_bits;
          held_nxt  = held_r - bfr_pkg::HELD_W'(odd_bits);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      held_r  <= '0;
      err_r   <= bfr_pkg::ERR_NONE;
    end else begin
      store_r <= store_nxt;
      held_r  <= held_nxt;
      err_r   <= err_nxt;
    end
  end

  assign res.field_value = value;
  assign res.status      = err_nxt;
  assign stat.held       = held_r;
  assign stat.err        = err_r;

endmodule

### sv/msb_bit_field_reader_top.sv
// Top level of the MSB-first bit field reader: input register, result register
// and stream handshakes around bfr_unit; depends on bfr_pkg and bfr_unit.
//
// One request is taken per clock cycle when the result side keeps up. A request
// is held in the input register and applied to the 64-bit bit store when it
// fires; a read's result is then loaded into the output register, from which it
// is presented. Push and align give no result. The store update (barrel shift and
// fill count) is combinational from the input register, so back-to-back requests
// on the same store need no gaps; only a stalled result holds back the next read.
module msb_bit_field_reader_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // byte_in[7:0], field_width[13:8], zero pad
  input  logic [2:0]  in_tuser,   // func[1:0], sign_extend[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // field_value[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  logic             in_vld_r;
  bfr_pkg::item_t   item_r;
  logic             out_vld_r;
  bfr_pkg::result_t out_r;
  logic             is_read;
  logic             fire;
  bfr_pkg::result_t res;
  bfr_pkg::stat_t   stat;

  assign is_read   = (item_r.func == bfr_pkg::FUNC_READ);
  assign fire      = in_vld_r && (!is_read || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.func        <= in_tuser[1:0];
      item_r.byte_in     <= in_tdata[7:0];
      item_r.field_width <= in_tdata[13:8];
      item_r.sign_extend <= in_tuser[2];
    end
  end

  bfr_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res   (res),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && is_read) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_read) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.field_value;
  assign out_tuser  = out_r.status;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.held <= bfr_pkg::HELD_W'(bfr_pkg::STORE_BITS))
    else $error("fill count beyond store size");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.err != bfr_pkg::ERR_NONE |=> stat.err == $past(stat.err))
    else $error("sticky error changed");

  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_r.func == bfr_pkg::FUNC_ALIGN |=> stat.held[2:0] == 3'd0)
    else $error("align left a partial byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_read |-> !out_vld_r || out_tready)
    else $error("result register overwritten while held");

endmodule
